// ===== rtl/suk_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// suk_pkg: shared types for the sorted unique key set
// key type and the compare flags that every cell hands to its neighbor
// ----------------------------------------------------------------------------
package suk_pkg;

    localparam int KEY_W = 32;

    typedef logic signed [KEY_W-1:0] t_key;

    // compare result of one cell against the request key
    typedef struct packed {
        logic lt;   // occupied and stored key below request key
        logic eq;   // occupied and stored key equal to request key
    } t_cell_flag;

    // per-cell control from the top level
    typedef struct packed {
        logic occupied;  // cell index below key count
        logic commit;    // insert is taking place this cycle
    } t_cell_ctl;

endpackage : suk_pkg
`default_nettype wire

// ===== rtl/sorted_unique_key_set.sv =====
`default_nettype none
// a result is registered and valid in the cycle after its request transfer
// throughput: one request per cycle while the output is not stalled, set by the combinational compare in every cell
// a result waiting on a stalled output holds off further requests
// reset clears the key count and the output valid; stored keys are not cleared
// ----------------------------------------------------------------------------
// sorted_unique_key_set: bounded ascending set of signed 32-bit keys
// insert places a new key, if there is room, at its sorted place and shifts larger keys up;
// lookup reports empty, found or not found
// ----------------------------------------------------------------------------
module sorted_unique_key_set #(
    parameter int CAPACITY = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // request channel
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic              i_in_cmd,
    input  wire suk_pkg::t_key     i_in_key,
    // result channel
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [2:0]             o_out_status,
    output logic [4:0]             o_out_occupancy
);
    import suk_pkg::*;

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int OCC_W = 5;

    // request codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // result codes
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_FOUND     = 3'd3;
    localparam logic [2:0] ST_NOTFOUND  = 3'd4;
    localparam logic [2:0] ST_EMPTY     = 3'd5;

    // key count, the only control state of the set apart from the output valid
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    // output register
    logic          r_out_valid;
    logic          n_out_valid;
    logic [2:0]    r_status;
    logic [2:0]    n_status;
    logic [4:0]    r_occ;

    // chain wiring
    t_key          w_key  [CAPACITY];
    t_cell_flag    w_flag [CAPACITY];
    logic [CAPACITY-1:0] w_eq;

    logic          w_accept;
    logic          w_present;
    logic          w_full;
    logic          w_commit;
    logic [CW+OCC_W-1:0] w_occ_ext;

    // a new request is taken whenever the output register is free or draining
    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;

    // row of cells, each compares in parallel and passes its key and flag up
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        t_cell_ctl  w_ctl;
        t_key       w_left_key;
        t_cell_flag w_left_flag;

        assign w_ctl.occupied = (CW'(gi) < r_count);
        assign w_ctl.commit   = w_commit;

        if (gi == 0) begin : g_first
            // bottom slot: nothing below, so it sees a smaller neighbor
            assign w_left_key  = i_in_key;
            assign w_left_flag = '{lt: 1'b1, eq: 1'b0};
        end else begin : g_rest
            assign w_left_key  = w_key[gi-1];
            assign w_left_flag = w_flag[gi-1];
        end

        suk_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_new_key   (i_in_key),
            .i_left_key  (w_left_key),
            .i_left_flag (w_left_flag),
            .o_key       (w_key[gi]),
            .o_flag      (w_flag[gi])
        );

        assign w_eq[gi] = w_flag[gi].eq;
    end

    assign w_present = |w_eq;
    assign w_full    = (r_count == CW'(CAPACITY));

    // only a new key into a set with room changes the chain
    assign w_commit = w_accept & (i_in_cmd == CMD_INSERT) & ~w_present & ~w_full;

    always_comb begin
        n_count = r_count;
        if (w_commit) begin
            n_count = r_count + 1'b1;
        end
    end

    // result code; a duplicate wins over full since the set is unchanged
    always_comb begin
        case (i_in_cmd)
            CMD_INSERT: begin
                if (w_present) begin
                    n_status = ST_DUPLICATE;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_INSERTED;
                end
            end
            CMD_LOOKUP: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else if (w_present) begin
                    n_status = ST_FOUND;
                end else begin
                    n_status = ST_NOTFOUND;
                end
            end
            default: begin
                n_status = ST_NOTFOUND;
            end
        endcase
    end

    // occupancy is reported modulo the field width
    assign w_occ_ext = {{OCC_W{1'b0}}, n_count};

    assign n_out_valid = w_accept | (r_out_valid & i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload loads on every request transfer
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_occ    <= w_occ_ext[OCC_W-1:0];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_status    = r_status;
    assign o_out_occupancy = r_occ;

    // an insert grows the set by exactly one
    a_count_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> (r_count == $past(r_count) + 1'b1))
        else $error("key count did not advance on insert");

    // a new key into a full set is refused as full
    a_full_refused : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_cmd == CMD_INSERT && w_full && !w_present)
        |=> (r_status == ST_FULL && r_count == $past(r_count)))
        else $error("insert into full set not refused");

    // the two lowest slots stay strictly ascending
    a_ascending : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CW'(2)) |-> (w_key[0] < w_key[1]))
        else $error("stored keys out of order");

    // the count never passes the capacity
    a_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |=> (r_count == CW'(CAPACITY)))
        else $error("key count exceeded capacity");

endmodule : sorted_unique_key_set
`default_nettype wire

// ===== rtl/suk_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// suk_cell: one slot of the sorted key chain
// compares its key with the request and on insert keeps, takes the new key,
// or takes the key of its lower neighbor
// ----------------------------------------------------------------------------
module suk_cell (
    input  wire logic               i_clk,
    input  wire suk_pkg::t_cell_ctl  i_ctl,
    input  wire suk_pkg::t_key       i_new_key,
    input  wire suk_pkg::t_key       i_left_key,
    input  wire suk_pkg::t_cell_flag i_left_flag,
    output suk_pkg::t_key            o_key,
    output suk_pkg::t_cell_flag      o_flag
);
    import suk_pkg::*;

    t_key r_key;
    t_key n_key;

    always_comb begin
        o_flag.lt = i_ctl.occupied & (r_key < i_new_key);
        o_flag.eq = i_ctl.occupied & (r_key == i_new_key);
    end

    // larger keys move up one place, the first non-smaller slot takes the new key
    always_comb begin
        n_key = r_key;
        if (i_ctl.commit && !o_flag.lt) begin
            n_key = i_left_flag.lt ? i_new_key : i_left_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key = r_key;

endmodule : suk_cell
`default_nettype wire

// ===== dv/suk_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// suk_tb_pkg: request and response codes for the key set testbench
// operation codes driven on the request channel and the status codes
// returned on the result channel
// ----------------------------------------------------------------------------
package suk_tb_pkg;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } suk_cmd_e;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_EMPTY     = 3'd5
    } suk_status_e;

endpackage : suk_tb_pkg

// ===== dv/suk_result_checker.sv =====
// ----------------------------------------------------------------------------
// suk_result_checker: response checker for the sorted unique key set
// keeps its own ordered copy of the key set, works out the status and
// occupancy of every accepted request and compares them in order with
// the results the block hands out
// ----------------------------------------------------------------------------
module suk_result_checker
    import suk_tb_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_stall,
    input  wire logic          i_in_cmd,
    input  wire suk_pkg::t_key i_in_key,
    input  wire logic          i_out_valid,
    input  wire logic          i_out_stall,
    input  wire logic [2:0]    i_out_status,
    input  wire logic [4:0]    i_out_occupancy,
    output int                 o_errors,
    output int                 o_pending
);

    typedef struct {
        suk_status_e status;
        logic [4:0]  occupancy;
    } t_reply;

    suk_pkg::t_key set_keys [CAPACITY];
    int unsigned   set_count;
    t_reply        pending_replies [$];
    int            mismatch_count = 0;

    // insert or look up one key in the shadow set, returning the reply
    function automatic t_reply key_set_apply(input suk_cmd_e cmd, input suk_pkg::t_key k);
        int unsigned pos;
        logic        present;
        t_reply      r;
        pos = 0;
        for (int i = 0; i < set_count; i++) begin
            if (set_keys[i] < k) pos++;
        end
        present = (pos < set_count) && (set_keys[pos] == k);
        if (cmd == OP_INSERT) begin
            if (present) begin
                r.status = ST_DUPLICATE;
            end else if (set_count >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                for (int i = set_count; i > pos; i--) set_keys[i] = set_keys[i-1];
                set_keys[pos] = k;
                set_count++;
                r.status = ST_INSERTED;
            end
        end else if (set_count == 0) begin
            r.status = ST_EMPTY;
        end else if (present) begin
            r.status = ST_FOUND;
        end else begin
            r.status = ST_NOT_FOUND;
        end
        r.occupancy = set_count[4:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            set_count = 0;
            pending_replies.delete();
        end else begin
            // result side first: a request taken on this edge answers later
            if (i_out_valid && !i_out_stall) begin
                if (pending_replies.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result, status %0d occupancy %0d",
                             $time, i_out_status, i_out_occupancy);
                end else begin
                    want = pending_replies.pop_front();
                    if (i_out_status !== want.status) begin
                        mismatch_count++;
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, want.status, i_out_status);
                    end
                    if (i_out_occupancy !== want.occupancy) begin
                        mismatch_count++;
                        $display("%0t: occupancy mismatch, expected %0d actual %0d",
                                 $time, want.occupancy, i_out_occupancy);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pending_replies.push_back(key_set_apply(suk_cmd_e'(i_in_cmd), i_in_key));
            end
        end
        o_errors  <= mismatch_count;
        o_pending <= pending_replies.size();
    end

endmodule : suk_result_checker

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the sorted unique key set
// drives a directed run over the key extremes, duplicates, the full set
// and the empty lookup, then random inserts and lookups with random gaps
// on both channels; a separate checker predicts and compares every result
// ----------------------------------------------------------------------------
module tb_top;
    import suk_tb_pkg::*;

    localparam int          CAPACITY    = 16;
    localparam int          N_RANDOM    = 900;
    // run bound, many times over the worst case
    localparam int unsigned CYCLE_LIMIT = 200000;

    localparam suk_pkg::t_key KEY_MIN = 32'sh8000_0000;
    localparam suk_pkg::t_key KEY_MAX = 32'sh7fff_ffff;

    // keys that top up the set to capacity, in scrambled order so that
    // inserts land at the front, the back and the middle
    localparam suk_pkg::t_key FILL_KEYS [11] = '{
        32'sd100, -32'sd100, 32'sd50, 32'sd7, -32'sd7, 32'sh4000_0000,
        -32'sh4000_0000, 32'sd3, 32'sd2, -32'sd2, 32'sd1000
    };

    logic          clk;
    logic          rst_n      = 1'b0;
    logic          req_valid  = 1'b0;
    logic          req_cmd    = 1'b0;
    suk_pkg::t_key req_key    = '0;
    logic          req_stall;
    logic          rsp_valid;
    logic          rsp_stall  = 1'b0;
    logic [2:0]    rsp_status;
    logic [4:0]    rsp_occupancy;

    int            chk_errors;
    int            chk_pending;
    int unsigned   cycle_count = 0;
    int unsigned   sent_items  = 0;
    // every key ever offered for insert, used to aim lookups and repeats
    suk_pkg::t_key offered_keys [$];

    sorted_unique_key_set #(
        .CAPACITY (CAPACITY)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (req_valid),
        .o_in_stall      (req_stall),
        .i_in_cmd        (req_cmd),
        .i_in_key        (req_key),
        .o_out_valid     (rsp_valid),
        .i_out_stall     (rsp_stall),
        .o_out_status    (rsp_status),
        .o_out_occupancy (rsp_occupancy)
    );

    suk_result_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (req_valid),
        .i_in_stall      (req_stall),
        .i_in_cmd        (req_cmd),
        .i_in_key        (req_key),
        .i_out_valid     (rsp_valid),
        .i_out_stall     (rsp_stall),
        .i_out_status    (rsp_status),
        .i_out_occupancy (rsp_occupancy),
        .o_errors        (chk_errors),
        .o_pending       (chk_pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // one request transfer: optional idle gap, then hold valid and payload
    // until the block takes it; every 80 items starts with a gap-free run
    task automatic send_request(input suk_cmd_e cmd, input suk_pkg::t_key key);
        int unsigned gap;
        gap = (sent_items % 80 < 20) ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_cmd   <= cmd;
        req_key   <= key;
        do @(posedge clk); while (req_stall);
        sent_items++;
        if (cmd == OP_INSERT) offered_keys.push_back(key);
    endtask

    // hold off new requests until every outstanding result has come back;
    // the first edge lets the checker count the last transfer
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (chk_pending != 0) @(posedge clk);
    endtask

    // key mix: plain random, already offered keys (hits and duplicates),
    // their neighbors, the extremes and a small band around zero
    function automatic suk_pkg::t_key pick_key();
        suk_pkg::t_key k;
        int unsigned   sel;
        sel = $urandom_range(0, 9);
        k   = $urandom;
        if (sel >= 4 && sel <= 6 && offered_keys.size() > 0) begin
            k = offered_keys[$urandom_range(0, offered_keys.size() - 1)];
        end else if (sel == 7 && offered_keys.size() > 0) begin
            k = offered_keys[$urandom_range(0, offered_keys.size() - 1)];
            k = $urandom_range(0, 1) ? k + 1 : k - 1;
        end else if (sel == 8) begin
            case ($urandom_range(0, 3))
                0: k = KEY_MIN;
                1: k = KEY_MAX;
                2: k = '0;
                default: k = -1;
            endcase
        end else if (sel == 9) begin
            k = int'($urandom_range(0, 40)) - 20;
        end
        return k;
    endfunction

    // result side: stall at random before each result,
    // with a stall-free run at the start of every 70 results
    initial begin
        int unsigned hold;
        int unsigned taken;
        taken = 0;
        forever begin
            hold = (taken % 70 < 15) ? 0 : $urandom_range(0, 8);
            if (hold != 0) begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do @(posedge clk); while (!(rsp_valid && !rsp_stall));
            taken++;
        end
    end

    initial begin
        rst_n <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // lookup on an empty set
        send_request(OP_LOOKUP, '0);
        // extremes and the values around zero
        send_request(OP_INSERT, '0);
        send_request(OP_INSERT, KEY_MIN);
        send_request(OP_INSERT, KEY_MAX);
        send_request(OP_INSERT, -1);
        send_request(OP_INSERT, 1);
        // duplicates while there is still room
        send_request(OP_INSERT, '0);
        send_request(OP_INSERT, KEY_MAX);
        // hits at both ends and misses
        send_request(OP_LOOKUP, KEY_MIN);
        send_request(OP_LOOKUP, KEY_MAX);
        send_request(OP_LOOKUP, 5);
        send_request(OP_LOOKUP, KEY_MIN + 1);
        // fill up to capacity
        foreach (FILL_KEYS[i]) send_request(OP_INSERT, FILL_KEYS[i]);
        // new key into a full set, then a duplicate into a full set
        send_request(OP_INSERT, 5);
        send_request(OP_INSERT, -1);

        // let everything drain once before the random part
        wait_drained();

        for (int n = 0; n < N_RANDOM; n++) begin
            send_request($urandom_range(0, 1) ? OP_LOOKUP : OP_INSERT, pick_key());
            if (n == N_RANDOM / 2) wait_drained();
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (chk_errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule : tb_top
